// ===== rtl/core/buddy_block_allocator_top_assert.svh =====
// Assertion macros for the buddy block allocator.
// Used at the end of buddy_block_allocator_top; expects clk and rst_n in scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// Shared types, constants and functions for the buddy block allocator.
// No dependencies; imported by bba_ctrl, bba_dpath and the top level.
`default_nettype none

package bba_pkg;

  localparam int MAX_ORDER_DEF = 6;
  localparam int ID_WIDTH_DEF  = 8;
  localparam int ORD_W         = 3;   // width of a stored block order
  localparam int NEED_W        = 5;   // rounded request order, up to 16

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  owner_id;
    logic [15:0] request_size;
    logic [5:0]  query_index;
  } bba_in_t;

  typedef struct packed {
    logic       alloc_done;
    logic [6:0] block_count;
    logic [7:0] owner_out;
    logic       index_valid;
  } bba_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLIT,
    ST_CLAIM,
    ST_FINISH
  } bba_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // load the item, restart the walk at address 0
    logic step;      // advance to the next block
    logic seize;     // latch order of the fitting block before splitting
    logic split;     // halve the block, write its upper buddy
    logic claim;     // write the owner into the fitted block
    logic found;     // capture the queried owner
    logic load_out;  // move the result into the output register
  } bba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_query;
    logic at_end;      // walk ran past the region
    logic hit;         // current block fits or is the queried one
    logic exact;       // fitting block already has the needed order
    logic split_last;  // this split reaches the needed order
  } bba_sts_t;

  // Smallest order r with 2^r >= size, capped at 16.
  function automatic logic [NEED_W-1:0] need_order(input logic [15:0] size);
    logic [NEED_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if ((17'(1) << i) < 17'(size)) begin
        r = NEED_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
// Control state machine of the buddy block allocator.
// Depends on bba_pkg; drives bba_dpath through bba_cmd_t.
`default_nettype none

module bba_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  input  bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_cmd_t cmd
);
  import bba_pkg::*;

  bba_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.at_end) begin
          state_nxt = ST_FINISH;
        end else if (sts.hit) begin
          if (sts.is_query) begin
            cmd.found = 1'b1;
            state_nxt = ST_FINISH;
          end else if (sts.exact) begin
            cmd.claim = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            cmd.seize = 1'b1;
            state_nxt = ST_SPLIT;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        if (sts.split_last) begin
          state_nxt = ST_CLAIM;
        end
      end
      ST_CLAIM: begin
        cmd.claim = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/bba_dpath.sv =====
// Datapath of the buddy block allocator: block store, walk address, count,
// result and output registers. Depends on bba_pkg; commanded by bba_ctrl.
`default_nettype none

module bba_dpath #(
  parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF,
  parameter int ID_WIDTH  = bba_pkg::ID_WIDTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_wr_en,
  input  wire  [2:0]        cfg_wr_data,
  input  bba_pkg::bba_in_t  in_data,
  input  bba_pkg::bba_cmd_t cmd,
  output bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_out_t out_data
);
  import bba_pkg::*;

  localparam int AW    = MAX_ORDER;
  localparam int AW1   = MAX_ORDER + 1;
  localparam int DEPTH = 1 << MAX_ORDER;
  localparam int IDX_W = (ID_WIDTH > 8) ? ID_WIDTH : 8;
  localparam int ENT_W = ORD_W + ID_WIDTH;

  // Block store, indexed by unit address: {order, owner}.
  logic [ENT_W-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0]    vld_r;
  logic [ENT_W-1:0]    rd_data_r;
  logic                rd_vld_r;

  logic [ORD_W-1:0]    tot_r;
  logic [AW1-1:0]      cnt_r;
  logic [AW1-1:0]      addr_r, addr_nxt;
  logic [AW1-1:0]      k_r;
  logic [ORD_W-1:0]    ord_r;
  logic                op_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [NEED_W-1:0]   need_r;
  logic [5:0]          qidx_r;
  logic                res_done_r;
  logic [7:0]          res_own_r;
  logic                res_vld_r;
  bba_out_t            out_data_r;

  logic [ORD_W-1:0]    cur_ord;
  logic [ID_WIDTH-1:0] cur_owner;
  logic [AW1-1:0]      limit;
  logic                in_range;
  logic                fit;
  logic                at_idx;
  logic [ORD_W-1:0]    ord_dec;
  logic [AW1-1:0]      buddy;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ENT_W-1:0]    wr_data;
  logic [IDX_W-1:0]    id_ext;
  logic [IDX_W-1:0]    own_ext;
  logic [ORD_W-1:0]    cfg_sat;

  // An entry never written since init reads as its init value.
  always_comb begin
    if (rd_vld_r) begin
      cur_ord   = rd_data_r[ENT_W-1 -: ORD_W];
      cur_owner = rd_data_r[ID_WIDTH-1:0];
    end else begin
      cur_ord   = (addr_r == '0) ? tot_r : '0;
      cur_owner = '0;
    end
  end

  assign limit    = AW1'(1) << tot_r;
  assign in_range = (addr_r < limit);
  assign fit      = (cur_owner == '0) && (NEED_W'(cur_ord) >= need_r);
  assign at_idx   = (7'(k_r) == 7'(qidx_r));
  assign ord_dec  = ord_r - ORD_W'(1);
  assign buddy    = addr_r + (AW1'(1) << ord_dec);
  assign id_ext   = IDX_W'(in_data.owner_id);
  assign own_ext  = IDX_W'(cur_owner);
  assign cfg_sat  = (cfg_wr_data > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : cfg_wr_data;

  always_comb begin
    sts.is_query   = (op_r == OP_QUERY);
    sts.at_end     = !in_range;
    sts.hit        = in_range && ((op_r == OP_QUERY) ? at_idx : fit);
    sts.exact      = (NEED_W'(cur_ord) == need_r);
    sts.split_last = (NEED_W'(ord_dec) == need_r);
  end

  // Split writes the upper buddy; claim writes the fitted block itself.
  always_comb begin
    wr_en = cmd.split | cmd.claim;
    if (cmd.split) begin
      wr_addr = buddy[AW-1:0];
      wr_data = {ord_dec, {ID_WIDTH{1'b0}}};
    end else begin
      wr_addr = addr_r[AW-1:0];
      wr_data = {need_r[ORD_W-1:0], id_r};
    end
  end

  always_comb begin
    if (cmd.start) begin
      addr_nxt = '0;
    end else if (cmd.step) begin
      addr_nxt = addr_r + (AW1'(1) << cur_ord);
    end else begin
      addr_nxt = addr_r;
    end
  end

  // Read ahead: data for the next walk address lands with it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[addr_nxt[AW-1:0]];
    rd_vld_r  <= vld_r[addr_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= ORD_W'(MAX_ORDER);
      cnt_r <= AW1'(1);
      vld_r <= '0;
    end else if (cfg_wr_en) begin
      tot_r <= cfg_sat;
      cnt_r <= AW1'(1);
      vld_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.split) begin
        cnt_r <= cnt_r + AW1'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (cmd.start) begin
      op_r       <= in_data.op;
      id_r       <= id_ext[ID_WIDTH-1:0];
      need_r     <= need_order(in_data.request_size);
      qidx_r     <= in_data.query_index;
      k_r        <= '0;
      res_done_r <= 1'b0;
      res_own_r  <= '0;
      res_vld_r  <= 1'b0;
    end else begin
      if (cmd.step) begin
        k_r <= k_r + AW1'(1);
      end
      if (cmd.claim) begin
        res_done_r <= 1'b1;
      end
      if (cmd.found) begin
        res_own_r <= own_ext[7:0];
        res_vld_r <= 1'b1;
      end
    end
    if (cmd.seize) begin
      ord_r <= cur_ord;
    end else if (cmd.split) begin
      ord_r <= ord_dec;
    end
    if (cmd.load_out) begin
      out_data_r.alloc_done  <= res_done_r;
      out_data_r.block_count <= 7'(cnt_r);
      out_data_r.owner_out   <= res_own_r;
      out_data_r.index_valid <= res_vld_r;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/buddy_block_allocator_top.sv =====
// Buddy block allocator: one result beat per input beat, one item at a time.
// The walk visits one block per cycle; a fitting block that is too large is split down
// to the needed order before it is claimed. A new item is taken on return to idle,
// even while the previous result waits. Synchronous reset: one free block of order
// MAX_ORDER, output empty; a total_order write restores one free block at once.
`default_nettype none

module buddy_block_allocator_top #(
  parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF,
  parameter int ID_WIDTH  = bba_pkg::ID_WIDTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_wr_en,
  input  wire  [2:0]        cfg_wr_data,
  input  wire               in_valid,
  output logic              in_stall,
  input  bba_pkg::bba_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output bba_pkg::bba_out_t out_data
);
  import bba_pkg::*;

  bba_cmd_t   cmd;
  bba_sts_t   sts;
  logic [4:0] cmd_bits;
  logic       alloc_beat;
  logic       no_query_fields;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dpath #(
    .MAX_ORDER(MAX_ORDER),
    .ID_WIDTH (ID_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_data    (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_data   (out_data)
  );

  assign cmd_bits        = {cmd.step, cmd.seize, cmd.split, cmd.claim, cmd.found};
  assign alloc_beat      = out_valid && out_data.alloc_done;
  assign no_query_fields = !out_data.index_valid && (out_data.owner_out == 8'd0);

`include "buddy_block_allocator_top_assert.svh"

  `BBA_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "accepted beat left block idle")
  `BBA_ASSERT_NOW(a_one_command, 1'b1, $onehot0(cmd_bits), "conflicting datapath commands")
  `BBA_ASSERT_NOW(a_count_nz, out_valid, out_data.block_count != 7'd0, "zero block count")
  `BBA_ASSERT_NOW(a_alloc_fields, alloc_beat, no_query_fields, "alloc beat has query fields")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for buddy_block_allocator_top.
// Depends on bba_pkg for the beat types and opcodes; mirrors the block store to predict
// each result beat and compares it field by field under random idling and backpressure.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int REGION      = 1 << MAX_ORDER_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int IN_W        = $bits(bba_in_t);

  logic     clk;
  logic     rst_n;
  logic     cfg_wr_en;
  logic [2:0] cfg_wr_data;
  logic     in_valid;
  logic     in_stall;
  bba_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  bba_out_t out_data;

  buddy_block_allocator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Mirror of the block store, indexed by unit address.
  int unsigned region_order;
  logic [2:0]  blk_order [REGION];
  logic [7:0]  blk_owner [REGION];
  int unsigned blk_count;

  bba_out_t    alloc_replies[$];
  int unsigned fails = 0;
  int unsigned quiet = 0;
  int unsigned hold_seq = 0;
  bit          idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void load_region(int unsigned ord);
    for (int i = 0; i < REGION; i++) begin
      blk_order[i] = '0;
      blk_owner[i] = '0;
    end
    region_order = (ord > MAX_ORDER_DEF) ? MAX_ORDER_DEF : ord;
    blk_order[0] = 3'(region_order);
    blk_count = 1;
  endfunction

  function automatic int unsigned size_to_order(logic [15:0] size);
    int unsigned r;
    r = 0;
    while (r < 16 && (32'd1 << r) < 32'(size)) r++;
    return r;
  endfunction

  function automatic bba_out_t buddy_step(bba_in_t it);
    bba_out_t    res;
    int unsigned need;
    int unsigned addr;
    int unsigned ord;
    int unsigned k;
    int unsigned span;
    bit          placed;
    res = '0;
    span = 1 << region_order;
    addr = 0;
    placed = 1'b0;
    if (it.op == OP_ALLOC) begin
      need = size_to_order(it.request_size);
      while (addr < span && !placed) begin
        ord = blk_order[addr];
        if (blk_owner[addr] == '0 && ord >= need) begin
          // halve in place, keep the lower half, free the upper buddy
          while (ord > need) begin
            ord--;
            blk_order[addr] = 3'(ord);
            blk_order[addr + (1 << ord)] = 3'(ord);
            blk_owner[addr + (1 << ord)] = '0;
            blk_count++;
          end
          blk_owner[addr] = it.owner_id;
          placed = 1'b1;
        end else begin
          addr += 1 << ord;
        end
      end
      res.alloc_done = placed;
    end else if (it.query_index < blk_count) begin
      k = 0;
      while (addr < span && !res.index_valid) begin
        if (k == it.query_index) begin
          res.owner_out = blk_owner[addr];
          res.index_valid = 1'b1;
        end else begin
          k++;
          addr += 1 << blk_order[addr];
        end
      end
    end
    res.block_count = 7'(blk_count);
    return res;
  endfunction

  function automatic void match_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Predict on every accepted input beat, check every accepted result beat.
  always @(posedge clk) begin : monitor
    bba_out_t want;
    if (rst_n && in_valid && !in_stall) begin
      alloc_replies.push_back(buddy_step(in_data));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (alloc_replies.size() == 0) begin
        $error("result beat with nothing outstanding");
        fails++;
      end else begin
        want = alloc_replies.pop_front();
        match_field("alloc_done", want.alloc_done, out_data.alloc_done);
        match_field("block_count", want.block_count, out_data.block_count);
        match_field("owner_out", want.owner_out, out_data.owner_out);
        match_field("index_valid", want.index_valid, out_data.index_valid);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet = quiet + 1;
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Result side: random stall bursts, plus a long hold-off on request.
  initial begin : receiver
    int unsigned burst;
    int unsigned hold_left;
    int unsigned hold_seen;
    burst = 0;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(0, 6);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_item(bba_in_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic bba_in_t mk_alloc(int unsigned id, int unsigned size);
    bba_in_t it;
    it.op = OP_ALLOC;
    it.owner_id = 8'(id);
    it.request_size = 16'(size);
    it.query_index = 6'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic bba_in_t mk_query(int unsigned idx);
    bba_in_t it;
    it.op = OP_QUERY;
    it.owner_id = 8'($urandom_range(0, 255));
    it.request_size = 16'($urandom_range(0, 65535));
    it.query_index = 6'(idx);
    return it;
  endfunction

  function automatic bba_in_t rand_item(bit fine);
    bba_in_t     it;
    int unsigned pick;
    int unsigned size;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      it = IN_W'($urandom);
    end else if (pick < 62) begin
      sel = $urandom_range(0, 9);
      if (fine) size = $urandom_range(0, 2);
      else if (sel < 6) size = $urandom_range(0, 1 << $urandom_range(0, 6));
      else if (sel < 8) size = 1 << $urandom_range(0, 6);
      else size = $urandom_range(0, 65535);
      it = mk_alloc(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255), size);
    end else begin
      it = mk_query((blk_count > 63) ? $urandom_range(0, 63) : $urandom_range(0, blk_count));
    end
    return it;
  endfunction

  task automatic wait_idle();
    in_valid = 1'b0;
    while (alloc_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_order(int unsigned v);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = 3'(v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    load_region(v);
  endtask

  task automatic test_reset_state();
    send_item(mk_query(0));
    send_item(mk_query(1));
  endtask

  task automatic test_directed();
    send_item(mk_alloc(255, 0));     // six splits down to one unit
    send_item(mk_alloc(0, 1));       // owner zero: block stays free
    send_item(mk_alloc(8'hAA, 1));   // same free unit taken again
    send_item(mk_alloc(8'h55, 3));
    send_item(mk_alloc(1, 65535));   // order far above the region: no fit
    send_item(mk_alloc(2, 65));
    send_item(mk_alloc(3, 32));
    send_item(mk_alloc(4, 33));      // nothing of order six left
    send_item(mk_query(2));
    send_item(mk_query(6));
    send_item(mk_query(63));         // beyond the block count
  endtask

  task automatic test_order_sweep();
    write_order(0);
    send_item(mk_alloc(1, 1));
    send_item(mk_alloc(2, 2));
    send_item(mk_query(0));
    send_item(mk_query(1));
    write_order(7);                  // saturates to the largest order
    send_item(mk_alloc(8'h80, 64));
    send_item(mk_query(0));
    send_item(mk_alloc(9, 1));
    write_order(3);
    send_item(mk_alloc(3, 5));
    send_item(mk_alloc(0, 0));
    send_item(mk_query(1));
  endtask

  task automatic test_backpressure();
    write_order(6);
    idle_on = 1'b0;
    hold_seq++;
    repeat (16) send_item(rand_item(1'b1));
    wait_idle();
  endtask

  task automatic test_random();
    int unsigned ord;
    int unsigned n;
    bit          fine;
    for (int ph = 0; ph < 22; ph++) begin
      case (ph % 4)
        0: ord = (ph % 8 == 0) ? 0 : 7;
        1: ord = 6;
        default: ord = $urandom_range(0, 7);
      endcase
      write_order(ord);
      idle_on = ($urandom_range(0, 3) != 0);
      fine = ($urandom_range(0, 2) == 0);
      n = $urandom_range(40, 70);
      repeat (n) send_item(rand_item(fine));
    end
  endtask

  task automatic test_quiet_tail();
    write_order(6);
    idle_on = 1'b0;
    repeat (100) send_item(rand_item(1'($urandom_range(0, 1))));
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    idle_on = 1'b1;
    load_region(MAX_ORDER_DEF);
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed();
    test_order_sweep();
    test_backpressure();
    test_random();
    test_quiet_tail();

    wait_idle();
    if (fails == 0 && alloc_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
